@@ rtl/csc_pkg.sv @@
// Shared types, constants and calendar functions of the calendar seconds converter.
`timescale 1ns / 1ps
package csc_pkg;

	localparam int YEAR_SPAN_DEF = 256;
	localparam int EPOCH_YEAR    = 1900;
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int ACC_W         = 38;
	localparam int IN_W          = 72;
	localparam int OUT_W         = 72;

	localparam logic [1:0] OP_TO_SECS = 2'd0;
	localparam logic [1:0] OP_TO_DATE = 2'd1;
	localparam logic [1:0] OP_ADD     = 2'd2;
	localparam logic [1:0] OP_SUB     = 2'd3;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_YACC,
		CMD_MACC,
		CMD_ADJ,
		CMD_CLAMP,
		CMD_YDEC,
		CMD_MDEC,
		CMD_DDEC,
		CMD_HDEC,
		CMD_NDEC,
		CMD_OUT
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YACC,
		ST_MACC,
		ST_ADJ,
		ST_CLAMP,
		ST_YDEC,
		ST_MDEC,
		ST_DDEC,
		ST_HDEC,
		ST_NDEC,
		ST_DONE
	} state_t;

	// divisible by 4, and not by 100 unless also by 16 (hence by 400)
	function automatic logic leap_f(input logic [11:0] y);
		logic [24:0] p;
		logic [5:0]  q;
		p = 25'(y) * 25'(5243);
		q = p[24:19];
		return (y[1:0] == 2'd0) && ((y != 12'(12'(q) * 12'(100))) || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [24:0] year_secs_f(input logic leap);
		return leap ? 25'(366 * SECS_PER_DAY) : 25'(365 * SECS_PER_DAY);
	endfunction

	function automatic logic [21:0] month_secs_f(input logic [3:0] m, input logic leap);
		logic [21:0] r;
		case (m)
			4'd2: begin
				r = leap ? 22'(29 * SECS_PER_DAY) : 22'(28 * SECS_PER_DAY);
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				r = 22'(30 * SECS_PER_DAY);
			end
			default: begin
				r = 22'(31 * SECS_PER_DAY);
			end
		endcase
		return r;
	endfunction

	function automatic logic [ACC_W-1:0] last_second_f(input int span);
		logic [ACC_W-1:0] t;
		t = '0;
		for (int i = 0; i < span; i++) begin
			t = t + ACC_W'(year_secs_f(leap_f(12'(EPOCH_YEAR + i))));
		end
		return t - ACC_W'(1);
	endfunction

endpackage

@@ rtl/csc_ctrl.sv @@
// Sequencer of the calendar seconds converter: walks the conversion loops.
`timescale 1ns / 1ps
module csc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  logic          cont,
	output csc_pkg::cmd_t cmd
);
	import csc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd     = CMD_LOAD;
					state_d = ST_YACC;
				end
			end
			ST_YACC: begin
				cmd = CMD_YACC;
				if (!cont) state_d = ST_MACC;
			end
			ST_MACC: begin
				cmd = CMD_MACC;
				if (!cont) state_d = ST_ADJ;
			end
			ST_ADJ: begin
				cmd     = CMD_ADJ;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd     = CMD_CLAMP;
				state_d = ST_YDEC;
			end
			ST_YDEC: begin
				cmd = CMD_YDEC;
				if (!cont) state_d = ST_MDEC;
			end
			ST_MDEC: begin
				cmd = CMD_MDEC;
				if (!cont) state_d = ST_DDEC;
			end
			ST_DDEC: begin
				cmd = CMD_DDEC;
				if (!cont) state_d = ST_HDEC;
			end
			ST_HDEC: begin
				cmd = CMD_HDEC;
				if (!cont) state_d = ST_NDEC;
			end
			ST_NDEC: begin
				cmd = CMD_NDEC;
				if (!cont) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd     = CMD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd == CMD_OUT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT) |-> (!m_tvalid_q || m_tready))
		else $error("result beat overwritten while still pending");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_YACC))
		else $error("accepted beat did not start the year walk");
`endif

endmodule

@@ rtl/csc_datapath.sv @@
// Datapath of the calendar seconds converter: accumulator, counters and result register.
`timescale 1ns / 1ps
module csc_datapath #(
	parameter int YEAR_SPAN = csc_pkg::YEAR_SPAN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csc_pkg::cmd_t             cmd,
	output logic                      cont,
	input  logic [csc_pkg::IN_W-1:0]  s_tdata,
	input  logic [1:0]                s_tuser,
	output logic [csc_pkg::OUT_W-1:0] m_tdata,
	output logic [0:0]                m_tuser
);
	import csc_pkg::*;

	localparam logic [ACC_W-1:0] LAST       = last_second_f(YEAR_SPAN);
	localparam logic [11:0]      LAST_YEAR  = 12'(EPOCH_YEAR + YEAR_SPAN - 1);
	localparam logic [11:0]      EPOCH_Y    = 12'(EPOCH_YEAR);
	localparam logic             EPOCH_LEAP = leap_f(12'(EPOCH_YEAR));

	logic [1:0]       op_q;
	logic [3:0]       mon_in_q;
	logic [11:0]      yr_in_q;
	logic             in_leap_q;
	logic [32:0]      amount_q;
	logic [ACC_W-1:0] acc_q;
	logic [11:0]      yr_q;
	logic             yr_leap_q;
	logic [3:0]       mon_q;
	logic [4:0]       day_q;
	logic [4:0]       hr_q;
	logic [5:0]       mi_q;
	logic [32:0]      t_q;
	logic             flag_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_flag_q;

	logic [ACC_W-1:0] acc_ld;
	logic [ACC_W-1:0] yacc_sum;
	logic [ACC_W-1:0] macc_sum;
	logic [ACC_W-1:0] ydiff;
	logic [ACC_W-1:0] mdiff;
	logic [ACC_W-1:0] ddiff;
	logic [ACC_W-1:0] hdiff;
	logic [ACC_W-1:0] ndiff;
	logic [11:0]      yr_inc;

	assign acc_ld = ACC_W'(s_tdata[25:21]) * ACC_W'(SECS_PER_HOUR)
		+ ACC_W'(s_tdata[31:26]) * ACC_W'(SECS_PER_MIN)
		+ ACC_W'(s_tdata[37:32])
		+ ACC_W'(s_tdata[4:0]) * ACC_W'(SECS_PER_DAY)
		- ACC_W'(SECS_PER_DAY);

	assign yr_inc   = yr_q + 12'd1;
	assign yacc_sum = acc_q + ACC_W'(year_secs_f(yr_leap_q));
	assign macc_sum = acc_q + ACC_W'(month_secs_f(mon_q, in_leap_q));
	assign ydiff    = acc_q - ACC_W'(year_secs_f(yr_leap_q));
	assign mdiff    = acc_q - ACC_W'(month_secs_f(mon_q, yr_leap_q));
	assign ddiff    = acc_q - ACC_W'(SECS_PER_DAY);
	assign hdiff    = acc_q - ACC_W'(SECS_PER_HOUR);
	assign ndiff    = acc_q - ACC_W'(SECS_PER_MIN);

	always_comb begin
		case (cmd)
			CMD_YACC: cont = (op_q != OP_TO_DATE) && (yr_q < yr_in_q);
			CMD_MACC: cont = (op_q != OP_TO_DATE) && (mon_q < mon_in_q);
			CMD_YDEC: cont = (yr_q < LAST_YEAR) && !ydiff[ACC_W-1];
			CMD_MDEC: cont = (mon_q < 4'd12) && !mdiff[ACC_W-1];
			CMD_DDEC: cont = !ddiff[ACC_W-1];
			CMD_HDEC: cont = !hdiff[ACC_W-1];
			CMD_NDEC: cont = !ndiff[ACC_W-1];
			default:  cont = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q      <= s_tuser;
				mon_in_q  <= s_tdata[8:5];
				yr_in_q   <= s_tdata[20:9];
				in_leap_q <= leap_f(s_tdata[20:9]);
				amount_q  <= s_tdata[70:38];
				acc_q     <= (s_tuser == OP_TO_DATE) ? ACC_W'(s_tdata[70:38]) : acc_ld;
				yr_q      <= EPOCH_Y;
				yr_leap_q <= EPOCH_LEAP;
				mon_q     <= 4'd1;
			end
			CMD_YACC: begin
				if (cont) begin
					acc_q     <= yacc_sum;
					yr_q      <= yr_inc;
					yr_leap_q <= leap_f(yr_inc);
				end
			end
			CMD_MACC: begin
				if (cont) begin
					acc_q <= macc_sum;
					mon_q <= mon_q + 4'd1;
				end
			end
			CMD_ADJ: begin
				if (op_q == OP_ADD) begin
					acc_q <= acc_q + ACC_W'(amount_q);
				end else if (op_q == OP_SUB) begin
					acc_q <= acc_q - ACC_W'(amount_q);
				end
			end
			CMD_CLAMP: begin
				if (acc_q[ACC_W-1]) begin
					acc_q  <= '0;
					t_q    <= '0;
					flag_q <= 1'b1;
				end else if (acc_q > LAST) begin
					acc_q  <= LAST;
					t_q    <= LAST[32:0];
					flag_q <= 1'b1;
				end else begin
					t_q    <= acc_q[32:0];
					flag_q <= 1'b0;
				end
				yr_q      <= EPOCH_Y;
				yr_leap_q <= EPOCH_LEAP;
				mon_q     <= 4'd1;
				day_q     <= 5'd1;
				hr_q      <= 5'd0;
				mi_q      <= 6'd0;
			end
			CMD_YDEC: begin
				if (cont) begin
					acc_q     <= ydiff;
					yr_q      <= yr_inc;
					yr_leap_q <= leap_f(yr_inc);
				end
			end
			CMD_MDEC: begin
				if (cont) begin
					acc_q <= mdiff;
					mon_q <= mon_q + 4'd1;
				end
			end
			CMD_DDEC: begin
				if (cont) begin
					acc_q <= ddiff;
					day_q <= day_q + 5'd1;
				end
			end
			CMD_HDEC: begin
				if (cont) begin
					acc_q <= hdiff;
					hr_q  <= hr_q + 5'd1;
				end
			end
			CMD_NDEC: begin
				if (cont) begin
					acc_q <= ndiff;
					mi_q  <= mi_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_data_q <= '0;
			out_flag_q <= 1'b0;
		end else if (cmd == CMD_OUT) begin
			out_data_q <= {1'b0, acc_q[5:0], mi_q, hr_q, yr_q, mon_q, day_q, t_q};
			out_flag_q <= flag_q;
		end
	end

	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_flag_q;

`ifndef SYNTH
	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_CLAMP) |=> (!acc_q[ACC_W-1] && (acc_q <= LAST)))
		else $error("clamped seconds outside the supported span");
	a_month_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_MDEC) |-> ((mon_q >= 4'd1) && (mon_q <= 4'd12)))
		else $error("month counter left 1..12 during decomposition");
	a_fields_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT) |-> ((acc_q < ACC_W'(SECS_PER_MIN)) && (hr_q < 5'd24)
			&& (mi_q < 6'd60) && (day_q != 5'd0)))
		else $error("decomposed time fields out of range at result load");
`endif

endmodule

@@ rtl/calendar_seconds_converter_unit.sv @@
// Top level of the calendar seconds converter: date-time to and from seconds since 1900.
// The conversion time is set by the year, month, day, hour and minute walks of the
//   shared accumulator.
// Overlap: the next beat is taken once the result is registered, while that result
//   may still wait for m_tready.
// Reset: arst_n clears the sequencer, the output valid and the result register;
//   the accumulator, counters and input registers have no reset.
`timescale 1ns / 1ps
module calendar_seconds_converter_unit #(
	parameter int YEAR_SPAN = csc_pkg::YEAR_SPAN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// day, month, year, hour, minute, second, amount, pad
	input  logic [csc_pkg::IN_W-1:0]  s_tdata,
	// operation
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// total_seconds, result_day, result_month, result_year, result_hour,
	// result_minute, result_second, pad
	output logic [csc_pkg::OUT_W-1:0] m_tdata,
	// out_of_range
	output logic [0:0]                m_tuser
);
	import csc_pkg::*;

	cmd_t cmd;
	logic cont;

	csc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cont     (cont),
		.cmd      (cmd)
	);

	csc_datapath #(
		.YEAR_SPAN (YEAR_SPAN)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cont    (cont),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

@@ tb/tb_calendar_seconds_converter_unit.sv @@
// Self-checking testbench for the calendar seconds converter: directed and random beats.
`timescale 1ns / 1ps
module tb_calendar_seconds_converter_unit;
	import csc_pkg::*;

	localparam int  SPAN        = YEAR_SPAN_DEF;
	localparam int  N_RANDOM    = 1950;
	localparam int  HOLD_CYCLES = 5000;
	localparam int  DRAIN_WAIT  = 3000;
	localparam longint CYCLE_LIMIT = 30000000;

	typedef struct {
		logic [1:0]  op;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [32:0] amount;
	} date_req_t;

	typedef struct {
		logic [32:0] secs;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        clamped;
	} date_result_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic [1:0]       s_tuser  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	date_req_t    pending_reqs_q[$];
	date_result_t expected_dates_q[$];
	date_req_t    cur_req;
	longint       span_last;
	logic         in_beat  = 1'b0;
	logic         out_beat = 1'b0;
	int           send_gap = 0;
	bit           send_steady = 1'b0;
	int           recv_wait = 0;
	bit           recv_steady = 1'b0;
	int           hold_left = 0;
	bit           hold_used = 1'b0;
	int           n_accepted = 0;
	int           n_results = 0;
	int           n_clamped = 0;
	int           n_fail = 0;
	int           op_count[4] = '{0, 0, 0, 0};
	longint       cycle_cnt = 0;

	calendar_seconds_converter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic bit is_leap(int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic longint month_len(int unsigned m, int unsigned y);
		if (m == 2) begin
			return is_leap(y) ? 29 : 28;
		end
		if (m == 4 || m == 6 || m == 9 || m == 11) begin
			return 30;
		end
		return 31;
	endfunction

	function automatic longint year_len_secs(int unsigned y);
		return (is_leap(y) ? 366 : 365) * longint'(SECS_PER_DAY);
	endfunction

	function automatic longint span_last_second();
		longint t;
		t = 0;
		for (int unsigned y = EPOCH_YEAR; y < EPOCH_YEAR + SPAN; y++) begin
			t += year_len_secs(y);
		end
		return t - 1;
	endfunction

	function automatic longint date_to_seconds(date_req_t r);
		longint t;
		t = longint'(r.hour) * 3600 + longint'(r.minute) * 60 + longint'(r.second);
		t += (longint'(r.day) - 1) * SECS_PER_DAY;
		for (int unsigned m = 1; m < r.month; m++) begin
			t += month_len(m, r.year) * SECS_PER_DAY;
		end
		for (int unsigned y = EPOCH_YEAR; y < r.year; y++) begin
			t += year_len_secs(y);
		end
		return t;
	endfunction

	function automatic date_result_t predict_conversion(date_req_t r);
		date_result_t res;
		longint t, n;
		int unsigned yr, mo, dy;
		case (r.op)
			OP_TO_DATE: t = longint'({31'b0, r.amount});
			OP_ADD:     t = date_to_seconds(r) + longint'({31'b0, r.amount});
			OP_SUB:     t = date_to_seconds(r) - longint'({31'b0, r.amount});
			default:    t = date_to_seconds(r);
		endcase
		res.clamped = 1'b0;
		if (t < 0) begin
			t = 0;
			res.clamped = 1'b1;
		end else if (t > span_last) begin
			t = span_last;
			res.clamped = 1'b1;
		end
		n  = t;
		yr = EPOCH_YEAR;
		mo = 1;
		dy = 1;
		while (yr < EPOCH_YEAR + SPAN - 1 && n >= year_len_secs(yr)) begin
			n -= year_len_secs(yr);
			yr++;
		end
		while (mo < 12 && n >= month_len(mo, yr) * SECS_PER_DAY) begin
			n -= month_len(mo, yr) * SECS_PER_DAY;
			mo++;
		end
		while (n >= SECS_PER_DAY) begin
			n -= SECS_PER_DAY;
			dy++;
		end
		res.secs   = t[32:0];
		res.day    = dy[4:0];
		res.month  = mo[3:0];
		res.year   = yr[11:0];
		res.hour   = 5'(n / 3600);
		res.minute = 6'((n % 3600) / 60);
		res.second = 6'(n % 60);
		return res;
	endfunction

	task automatic add_req(logic [1:0] op, int y, int mo, int d, int h, int mi, int s,
			logic [32:0] amt);
		date_req_t r;
		r.op     = op;
		r.year   = 12'(y);
		r.month  = 4'(mo);
		r.day    = 5'(d);
		r.hour   = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		r.amount = amt;
		pending_reqs_q.push_back(r);
		op_count[op]++;
	endtask

	function automatic logic [32:0] rand_amount33();
		return (33'($urandom_range(0, 1)) << 32) | 33'($urandom());
	endfunction

	task automatic add_random_req();
		int y, mo, d;
		logic [1:0] op;
		logic [32:0] amt;
		op = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 19) == 0) begin
			add_req(op, $urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
				$urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
				rand_amount33());
		end else begin
			y  = $urandom_range(EPOCH_YEAR, EPOCH_YEAR + SPAN - 1);
			mo = $urandom_range(1, 12);
			d  = $urandom_range(1, int'(month_len(mo, y)));
			case ($urandom_range(0, 4))
				0: amt = 33'($urandom_range(0, 100000));
				1: amt = 33'($urandom_range(0, 40000000));
				2: amt = 33'($urandom());
				3: amt = 33'(span_last) - 33'($urandom_range(0, 100000)) + 33'(50000);
				default: amt = rand_amount33();
			endcase
			add_req(op, y, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
				$urandom_range(0, 59), amt);
		end
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			n_fail++;
		end
	endtask

	// sender: hold the beat until taken, then idle or present the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_beat) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs_q.size() > 0) begin
				cur_req = pending_reqs_q.pop_front();
				s_tdata <= {1'b0, cur_req.amount, cur_req.second, cur_req.minute,
					cur_req.hour, cur_req.year, cur_req.month, cur_req.day};
				s_tuser <= cur_req.op;
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 49) == 0) begin
					send_steady = !send_steady;
				end
				send_gap = send_steady ? 0 : $urandom_range(0, 19);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall each result while it is offered by a random wait, which is zero in steady mode
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (out_beat) begin
				if ($urandom_range(0, 49) == 0) begin
					recv_steady = !recv_steady;
				end
				recv_wait = recv_steady ? 0 : $urandom_range(0, 19);
			end else if (m_tvalid && recv_wait > 0) begin
				recv_wait--;
			end
			m_tready <= (recv_wait == 0) && (hold_left == 0);
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (!hold_used && n_accepted >= 40) begin
			hold_left = HOLD_CYCLES;
			hold_used = 1'b1;
		end
	end

	always @(posedge clk) begin
		date_result_t want, seen;
		if (arst_n) begin
			in_beat  <= s_tvalid && s_tready;
			out_beat <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				expected_dates_q.push_back(predict_conversion(cur_req));
				n_accepted++;
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				if (m_tuser[0]) begin
					n_clamped++;
				end
				if (expected_dates_q.size() == 0) begin
					$error("result beat with no request outstanding");
					n_fail++;
				end else begin
					want        = expected_dates_q.pop_front();
					seen.secs   = m_tdata[32:0];
					seen.day    = m_tdata[37:33];
					seen.month  = m_tdata[41:38];
					seen.year   = m_tdata[53:42];
					seen.hour   = m_tdata[58:54];
					seen.minute = m_tdata[64:59];
					seen.second = m_tdata[70:65];
					seen.clamped = m_tuser[0];
					check_field("total_seconds", want.secs, seen.secs);
					check_field("result_day", want.day, seen.day);
					check_field("result_month", want.month, seen.month);
					check_field("result_year", want.year, seen.year);
					check_field("result_hour", want.hour, seen.hour);
					check_field("result_minute", want.minute, seen.minute);
					check_field("result_second", want.second, seen.second);
					check_field("out_of_range", want.clamped, seen.clamped);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, expected_dates_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [32:0] ones;
		ones      = '1;
		span_last = span_last_second();

		add_req(OP_TO_SECS, 1900, 1, 1, 0, 0, 0, '0);
		add_req(OP_TO_SECS, 2155, 12, 31, 23, 59, 59, ones);
		add_req(OP_TO_SECS, 1900, 1, 0, 0, 0, 0, '0);
		add_req(OP_TO_SECS, 4095, 15, 31, 31, 63, 63, ones);
		add_req(OP_TO_SECS, 0, 0, 31, 0, 0, 0, '0);
		add_req(OP_TO_SECS, 2000, 2, 29, 12, 0, 0, '0);
		add_req(OP_TO_SECS, 1900, 2, 29, 6, 30, 15, '0);
		add_req(OP_TO_SECS, 2100, 3, 1, 0, 0, 1, '0);
		add_req(OP_TO_SECS, 2024, 13, 5, 8, 0, 0, '0);
		add_req(OP_TO_SECS, 1904, 2, 29, 23, 59, 59, '0);
		add_req(OP_TO_DATE, 1900, 1, 1, 0, 0, 0, '0);
		add_req(OP_TO_DATE, 1900, 1, 1, 0, 0, 0, 33'(span_last));
		add_req(OP_TO_DATE, 1900, 1, 1, 0, 0, 0, 33'(span_last + 1));
		add_req(OP_TO_DATE, 1900, 1, 1, 0, 0, 0, ones);
		add_req(OP_TO_DATE, 2000, 6, 15, 0, 0, 0, 33'd3155760000);
		add_req(OP_ADD, 1999, 12, 31, 23, 59, 59, 33'd1);
		add_req(OP_ADD, 2024, 2, 29, 10, 20, 30, '0);
		add_req(OP_ADD, 2155, 12, 31, 23, 59, 59, 33'd1);
		add_req(OP_ADD, 1900, 1, 1, 0, 0, 0, ones);
		add_req(OP_SUB, 1900, 1, 1, 0, 0, 0, 33'd1);
		add_req(OP_SUB, 2000, 3, 1, 0, 0, 0, 33'd1);
		add_req(OP_SUB, 2155, 12, 31, 23, 59, 59, ones);
		add_req(OP_SUB, 2100, 3, 1, 0, 0, 0, 33'd86400);
		for (int i = 0; i < N_RANDOM; i++) begin
			add_random_req();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs_q.size() > 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (expected_dates_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d requests (%0d to-seconds, %0d to-date, %0d add, %0d subtract)",
			n_accepted, op_count[OP_TO_SECS], op_count[OP_TO_DATE], op_count[OP_ADD],
			op_count[OP_SUB]);
		$display("%0d results checked, %0d clamped, %0d mismatches, %0d cycles",
			n_results, n_clamped, n_fail, cycle_cnt);
		if (n_fail == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
